// ===== hdl/rdt_pkg.sv =====
// ----------------------------------------------------------------------------
// rdt_pkg
// shared types, codes and defaults of the registered down-timer table
// ----------------------------------------------------------------------------
package rdt_pkg;

  // payload field widths as seen on the channels
  localparam int FUNC_W        = 3;
  localparam int KEY_FIELD_W   = 16;
  localparam int VALUE_FIELD_W = 16;
  localparam int STATUS_W      = 2;
  localparam int COUNT_FIELD_W = 4;

  // parameter defaults
  localparam int SLOTS_DEFAULT       = 8;
  localparam int VALUE_WIDTH_DEFAULT = 16;
  localparam int KEY_WIDTH_DEFAULT   = 16;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DEL   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_WRITE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [KEY_FIELD_W-1:0]   timer_key;
    logic [VALUE_FIELD_W-1:0] timer_value;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [VALUE_FIELD_W-1:0] read_value;
    logic [COUNT_FIELD_W-1:0] active_timers;
  } out_beat_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_APPLY
  } seq_state_t;

endpackage

// ===== hdl/rdt_chan_if.sv =====
// ----------------------------------------------------------------------------
// rdt_chan_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface rdt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rdt_slot_store.sv =====
// ----------------------------------------------------------------------------
// rdt_slot_store
// key and value memories of the timer slots, one write and one read port
// ----------------------------------------------------------------------------
module rdt_slot_store #(
  parameter int SLOTS    = rdt_pkg::SLOTS_DEFAULT,
  parameter int KEY_BITS = rdt_pkg::KEY_FIELD_W,
  parameter int VAL_BITS = rdt_pkg::VALUE_FIELD_W,
  localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic                wr_key_en,
  input  logic [IW-1:0]       wr_idx,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic [VAL_BITS-1:0] wr_val,
  input  logic [IW-1:0]       rd_idx,
  output logic [KEY_BITS-1:0] rd_key,
  output logic [VAL_BITS-1:0] rd_val
);

  logic [KEY_BITS-1:0] key_mem [SLOTS];
  logic [VAL_BITS-1:0] val_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[wr_idx] <= wr_val;
    end
    if (wr_key_en) begin
      key_mem[wr_idx] <= wr_key;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_idx];
    rd_val <= val_mem[rd_idx];
  end

endmodule

// ===== hdl/registered_down_timer_table.sv =====
// ----------------------------------------------------------------------------
// registered_down_timer_table
// table of keyed down-timers with add, delete, write, read and tick
// ----------------------------------------------------------------------------
// Each input beat is one operation on a table of SLOTS timers. A small
// sequencer walks the slots from the highest index down, one slot per
// cycle, through a single registered read port of the key/value store and
// one key comparator; a tick decrements each registered nonzero timer as
// the walk passes it. After the walk the apply state does the add, delete
// or write and loads the result register. A new operation is accepted only
// once the sequencer is back in idle. The input is not ready during the
// walk; a finished result waits in the output register and does not hold
// off the next operation until a second result is due. There is no
// clearing pass: reset clears the valid bits and count, not the store.
// ----------------------------------------------------------------------------
module registered_down_timer_table #(
  parameter int SLOTS       = rdt_pkg::SLOTS_DEFAULT,
  parameter int VALUE_WIDTH = rdt_pkg::VALUE_WIDTH_DEFAULT,
  parameter int KEY_WIDTH   = rdt_pkg::KEY_WIDTH_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  rdt_chan_if.sink   in,
  rdt_chan_if.source out
);

  // effective stored widths: the field width caps the parameter
  localparam int KEY_BITS =
    (KEY_WIDTH < rdt_pkg::KEY_FIELD_W) ? KEY_WIDTH : rdt_pkg::KEY_FIELD_W;
  localparam int VAL_BITS =
    (VALUE_WIDTH < rdt_pkg::VALUE_FIELD_W) ? VALUE_WIDTH : rdt_pkg::VALUE_FIELD_W;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // sequencer
  rdt_pkg::seq_state_t state, state_next;

  // latched operation
  logic [rdt_pkg::FUNC_W-1:0] func_reg;
  logic [KEY_BITS-1:0]        key_reg;
  logic [VAL_BITS-1:0]        val_reg;

  // walk address and the slot whose data comes back from the store
  logic [IW-1:0] addr;
  logic          addr_live;
  logic [IW-1:0] q_idx;
  logic          q_valid;

  // walk results
  logic                hit_found;
  logic [IW-1:0]       hit_idx;
  logic [VAL_BITS-1:0] hit_val;
  logic                free_found;
  logic [IW-1:0]       free_idx;

  // slot valid bits and registered count
  logic [SLOTS-1:0] used;
  logic [CW-1:0]    used_count;
  logic [CW-1:0]    used_count_next;

  // store ports
  logic                st_wr_en;
  logic                st_wr_key_en;
  logic [IW-1:0]       st_wr_idx;
  logic [VAL_BITS-1:0] st_wr_val;
  logic [KEY_BITS-1:0] key_q;
  logic [VAL_BITS-1:0] val_q;

  // apply-cycle controls
  logic                        out_free;
  logic                        out_load;
  logic                        used_set;
  logic                        used_clr;
  logic [rdt_pkg::STATUS_W-1:0] status_c;
  logic [VAL_BITS-1:0]         rd_c;

  // result register
  logic                out_valid;
  rdt_pkg::out_beat_t  out_data;

  // zero-extension helpers for the result fields
  logic [VAL_BITS+rdt_pkg::VALUE_FIELD_W-1:0] rd_ext;
  logic [CW+rdt_pkg::COUNT_FIELD_W-1:0]       cnt_ext;

  logic accept;
  logic slot_match;

  assign accept     = in.valid && in.ready;
  assign out_free   = !out_valid || out.ready;
  assign slot_match = used[q_idx] && (key_q == key_reg);

  rdt_slot_store #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS),
    .VAL_BITS (VAL_BITS)
  ) u_store (
    .clk       (clk),
    .wr_en     (st_wr_en),
    .wr_key_en (st_wr_key_en),
    .wr_idx    (st_wr_idx),
    .wr_key    (key_reg),
    .wr_val    (st_wr_val),
    .rd_idx    (addr),
    .rd_key    (key_q),
    .rd_val    (val_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rdt_pkg::SEQ_IDLE: begin
        if (accept) state_next = rdt_pkg::SEQ_SCAN;
      end
      rdt_pkg::SEQ_SCAN: begin
        // last slot's data evaluated this cycle
        if (q_valid && (q_idx == '0)) state_next = rdt_pkg::SEQ_APPLY;
      end
      rdt_pkg::SEQ_APPLY: begin
        if (out_free) state_next = rdt_pkg::SEQ_IDLE;
      end
      default: state_next = rdt_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdt_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // outputs of the sequencer: store writes, valid-bit updates, result
  always_comb begin
    in.ready        = (state == rdt_pkg::SEQ_IDLE);
    out_load        = 1'b0;
    st_wr_en        = 1'b0;
    st_wr_key_en    = 1'b0;
    st_wr_idx       = q_idx;
    st_wr_val       = val_q - 1'b1;
    used_set        = 1'b0;
    used_clr        = 1'b0;
    used_count_next = used_count;
    status_c        = rdt_pkg::STAT_OK;
    rd_c            = '0;
    unique case (state)
      rdt_pkg::SEQ_SCAN: begin
        // tick: decrement the returning slot when registered and nonzero
        if (q_valid && (func_reg == rdt_pkg::FN_TICK) && used[q_idx] && (val_q != '0)) begin
          st_wr_en = 1'b1;
        end
      end
      rdt_pkg::SEQ_APPLY: begin
        out_load = out_free;
        case (func_reg)
          rdt_pkg::FN_ADD: begin
            st_wr_idx = free_idx;
            st_wr_val = val_reg;
            if (hit_found) begin
              status_c = rdt_pkg::STAT_PRESENT;
            end else if (free_found) begin
              st_wr_en        = out_free;
              st_wr_key_en    = out_free;
              used_set        = out_free;
              used_count_next = used_count + 1'b1;
            end else begin
              status_c = rdt_pkg::STAT_FULL;
            end
          end
          rdt_pkg::FN_DEL: begin
            if (hit_found) begin
              used_clr        = out_free;
              used_count_next = used_count - 1'b1;
            end else begin
              status_c = rdt_pkg::STAT_MISSING;
            end
          end
          rdt_pkg::FN_WRITE: begin
            st_wr_idx = hit_idx;
            st_wr_val = val_reg;
            if (hit_found) begin
              st_wr_en = out_free;
            end else begin
              status_c = rdt_pkg::STAT_MISSING;
            end
          end
          rdt_pkg::FN_READ: begin
            if (hit_found) begin
              rd_c = hit_val;
            end else begin
              status_c = rdt_pkg::STAT_MISSING;
            end
          end
          default: begin
            // tick and unused codes: nothing left to do
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // operation latch
  always_ff @(posedge clk) begin
    if (accept) begin
      func_reg <= in.data.func;
      key_reg  <= in.data.timer_key[KEY_BITS-1:0];
      val_reg  <= in.data.timer_value[VAL_BITS-1:0];
    end
  end

  // walk: address runs from the top slot down; data returns in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_live  <= 1'b0;
      q_valid    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (accept) begin
      addr_live  <= 1'b1;
      q_valid    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == rdt_pkg::SEQ_SCAN) begin
      q_valid <= addr_live;
      if (addr == '0) addr_live <= 1'b0;
      if (q_valid) begin
        // first hit and first free slot seen from the top win
        if (slot_match && !hit_found) hit_found <= 1'b1;
        if (!used[q_idx] && !free_found) free_found <= 1'b1;
      end
    end else begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr <= IW'(SLOTS - 1);
    end else if (state == rdt_pkg::SEQ_SCAN) begin
      q_idx <= addr;
      if (addr_live && (addr != '0)) addr <= addr - 1'b1;
      if (q_valid && slot_match && !hit_found) begin
        hit_idx <= q_idx;
        hit_val <= val_q;
      end
      if (q_valid && !used[q_idx] && !free_found) free_idx <= q_idx;
    end
  end

  // valid bits and count
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      used_count <= '0;
    end else begin
      if (used_set) used[free_idx] <= 1'b1;
      if (used_clr) used[hit_idx] <= 1'b0;
      if (out_load) used_count <= used_count_next;
    end
  end

  // result register
  assign rd_ext  = {{rdt_pkg::VALUE_FIELD_W{1'b0}}, rd_c};
  assign cnt_ext = {{rdt_pkg::COUNT_FIELD_W{1'b0}}, used_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.status        <= status_c;
      out_data.read_value    <= rd_ext[rdt_pkg::VALUE_FIELD_W-1:0];
      out_data.active_timers <= cnt_ext[rdt_pkg::COUNT_FIELD_W-1:0];
    end
  end

  assign out.valid = out_valid;
  assign out.data  = out_data;

  // count always tracks the valid bits
  a_count_matches : assert property (@(posedge clk) disable iff (rst)
    used_count == CW'($countones(used)))
    else $error("used count out of step with valid bits");

  // an accepted beat starts the walk
  a_accept_scans : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == rdt_pkg::SEQ_SCAN) && addr_live)
    else $error("accepted beat did not start the walk");

  // the walk is over when the bottom slot's data returns
  a_walk_done : assert property (@(posedge clk) disable iff (rst)
    (state == rdt_pkg::SEQ_SCAN && q_valid && q_idx == '0) |-> !addr_live)
    else $error("walk address still live at the bottom slot");

  // apply is reached only from the walk and ends with a result load
  a_apply_entry : assert property (@(posedge clk) disable iff (rst)
    $rose(state == rdt_pkg::SEQ_APPLY) |-> $past(state) == rdt_pkg::SEQ_SCAN)
    else $error("apply entered without a walk");

  a_apply_loads : assert property (@(posedge clk) disable iff (rst)
    (state == rdt_pkg::SEQ_APPLY && out_free) |=> out_valid && (state == rdt_pkg::SEQ_IDLE))
    else $error("apply left without loading a result");

endmodule
